// File: rtl/hcbd_pkg.sv
package hcbd_pkg;

   // Width of the line length limit register.
   localparam int MAX_LINE_BITS = 12;
   localparam logic [MAX_LINE_BITS-1:0] MAX_LINE_RESET = 12'd511;

   // Bits taken by one hex digit.
   localparam int HEX_DIGIT_BITS = 4;

   // Character codes.
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_X_LO = 8'h78;
   localparam logic [7:0] CHAR_X_UP = 8'h58;

   // Error codes.
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_LONG     = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;
   localparam logic [1:0] ERR_END      = 2'd3;

   typedef enum logic [4:0] {
      PH_SIZE    = 5'b00001,
      PH_DATA    = 5'b00010,
      PH_TRAILER = 5'b00100,
      PH_DONE    = 5'b01000,
      PH_ERROR   = 5'b10000
   } phase_type;

   typedef enum logic [6:0] {
      SC_BLANKS   = 7'b0000001,
      SC_ZERO     = 7'b0000010,
      SC_ZERO_X   = 7'b0000100,
      SC_DIGITS   = 7'b0001000,
      SC_ACCEPT   = 7'b0010000,
      SC_IGNORE   = 7'b0100000,
      SC_OVERFLOW = 7'b1000000
   } scan_step_type;

   // Status of one character fed into the line scanner.
   typedef struct packed {
      logic          too_long;
      scan_step_type step;
   } feed_flags_type;

   // One result item.
   typedef struct packed {
      logic [1:0] error_code;
      logic       message_done;
      logic       out_valid;
      logic [7:0] out_byte;
   } result_type;

   // Hex digit decode: bit 4 is set for a digit, bits 3:0 hold its value.
   function automatic logic [HEX_DIGIT_BITS:0] hex_digit(input logic [7:0] c);
      logic [HEX_DIGIT_BITS:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, HEX_DIGIT_BITS'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, HEX_DIGIT_BITS'(c - 8'h41 + 8'd10)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, HEX_DIGIT_BITS'(c - 8'h61 + 8'd10)};
      end
      return r;
   endfunction

   // Space, TAB, VT, FF and CR count as blanks.
   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) ||
             (c == 8'h0D);
   endfunction

endpackage

// File: rtl/http_chunked_body_decoder.sv
// Path: a result item passes the input register and then the result register.
// Throughput: one item per cycle; the input register and the result register
// each hold one item around the combinational decode step, so the block stalls
// only when the result side holds back.
// Reset: synchronous, active high; the decoder returns to the size line phase and
// the line length limit returns to 511.
module http_chunked_body_decoder #(
   parameter int SIZE_BITS     = 32,
   parameter int LINE_LEN_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // stream_ends
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] message_done,
                                    // [10:9] error_code, [15:11] zero
   output logic        rsp_tuser,   // out_valid
   // Line length limit register.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_data
);
   import hcbd_pkg::*;

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff;
   logic                     in_ends_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               rsp_data_ff;
   result_type               result;
   logic [MAX_LINE_BITS-1:0] max_line_ff;
   logic                     advance;
   logic                     fire;

   // Pipeline handshake: each stage moves on when the one after it frees up.
   assign advance     = !rsp_valid_ff || rsp_tready;
   assign fire        = in_valid_ff && advance;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_line_ff  <= MAX_LINE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_line_ff <= csr_data;
         end
      end
   end

   // Input and result payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_ends_ff <= req_tlast;
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   hcbd_core #(
      .SIZE_BITS     (SIZE_BITS),
      .LINE_LEN_BITS (LINE_LEN_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .in_byte  (in_byte_ff),
      .in_ends  (in_ends_ff),
      .max_line (max_line_ff),
      .result   (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.out_valid;
   assign rsp_tdata  = {5'b0, rsp_data_ff.error_code, rsp_data_ff.message_done,
                        rsp_data_ff.out_byte};

endmodule

// File: rtl/hcbd_feed.sv
module hcbd_feed #(
   parameter int SIZE_BITS     = 32,
   parameter int LINE_LEN_BITS = 12
) (
   input  logic                                 scan_en,
   input  logic [7:0]                           char_i,
   input  hcbd_pkg::scan_step_type              step_i,
   input  logic [LINE_LEN_BITS-1:0]             len_i,
   input  logic [SIZE_BITS-1:0]                 accum_i,
   input  logic [hcbd_pkg::MAX_LINE_BITS-1:0]   max_line,
   output hcbd_pkg::feed_flags_type             flags_o,
   output logic [LINE_LEN_BITS-1:0]             len_o,
   output logic [SIZE_BITS-1:0]                 accum_o
);
   import hcbd_pkg::*;

   localparam int CMP_BITS = (LINE_LEN_BITS > MAX_LINE_BITS) ? LINE_LEN_BITS : MAX_LINE_BITS;

   logic [HEX_DIGIT_BITS:0] hex;
   logic                    is_digit;
   logic                    accum_full;
   logic [SIZE_BITS-1:0]    accum_shift;

   assign hex         = hex_digit(char_i);
   assign is_digit    = hex[HEX_DIGIT_BITS];
   assign accum_full  = |accum_i[SIZE_BITS-1 -: HEX_DIGIT_BITS];
   assign accum_shift = {accum_i[SIZE_BITS-HEX_DIGIT_BITS-1:0], hex[HEX_DIGIT_BITS-1:0]};

   // One character of a size or trailer line: length check, then the size scan.
   always_comb begin
      logic          take_digit;
      scan_step_type step_nx;
      take_digit = 1'b0;
      step_nx    = step_i;

      case (step_i)
         SC_BLANKS: begin
            if (is_blank(char_i)) begin
               step_nx = SC_BLANKS;
            end else if (char_i == CHAR_ZERO) begin
               step_nx = SC_ZERO;
            end else if (is_digit) begin
               take_digit = 1'b1;
            end else if (char_i == CHAR_SEMI && len_i == '0) begin
               step_nx = SC_ACCEPT;
            end else begin
               step_nx = SC_IGNORE;
            end
         end
         SC_ZERO: begin
            if (char_i == CHAR_X_LO || char_i == CHAR_X_UP) begin
               step_nx = SC_ZERO_X;
            end else if (is_digit) begin
               take_digit = 1'b1;
            end else if (char_i == CHAR_SEMI) begin
               step_nx = SC_ACCEPT;
            end else begin
               step_nx = SC_IGNORE;
            end
         end
         SC_ZERO_X: begin
            if (is_digit) begin
               take_digit = 1'b1;
            end else begin
               step_nx = SC_IGNORE;
            end
         end
         SC_DIGITS: begin
            if (is_digit) begin
               take_digit = 1'b1;
            end else if (char_i == CHAR_SEMI) begin
               step_nx = SC_ACCEPT;
            end else begin
               step_nx = SC_IGNORE;
            end
         end
         default: begin
            step_nx = step_i;
         end
      endcase

      flags_o.too_long = (CMP_BITS'(len_i) >= CMP_BITS'(max_line));
      flags_o.step     = step_i;
      accum_o          = accum_i;
      len_o            = len_i;

      if (!flags_o.too_long) begin
         if (scan_en) begin
            if (take_digit) begin
               // A digit that would push bits out of the size marks overflow.
               if (accum_full) begin
                  flags_o.step = SC_OVERFLOW;
               end else begin
                  flags_o.step = SC_DIGITS;
                  accum_o      = accum_shift;
               end
            end else begin
               flags_o.step = step_nx;
            end
         end
         // The line counter saturates at its top value.
         if (!(&len_i)) begin
            len_o = len_i + LINE_LEN_BITS'(1);
         end
      end
   end

endmodule

// File: rtl/hcbd_core.sv
module hcbd_core #(
   parameter int SIZE_BITS     = 32,
   parameter int LINE_LEN_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               fire,
   input  logic [7:0]                         in_byte,
   input  logic                               in_ends,
   input  logic [hcbd_pkg::MAX_LINE_BITS-1:0] max_line,
   output hcbd_pkg::result_type               result
);
   import hcbd_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [SIZE_BITS-1:0]    bytes_left_ff, bytes_left_in;
   logic [SIZE_BITS-1:0]    accum_ff, accum_in;
   logic [LINE_LEN_BITS-1:0] len_ff, len_in;
   scan_step_type           step_ff, step_in;
   logic [1:0]              err_ff, err_in;
   logic                    cr_ff, cr_in;

   feed_flags_type           a_flags, b_flags;
   logic [LINE_LEN_BITS-1:0] a_len, b_len, b_len_i;
   logic [SIZE_BITS-1:0]     a_accum, b_accum, b_accum_i;
   scan_step_type            b_step_i;
   logic                     scan_en;
   logic [SIZE_BITS-1:0]     bytes_dec;

   assign scan_en   = (phase_ff == PH_SIZE);
   assign bytes_dec = bytes_left_ff - SIZE_BITS'(1);

   // First feed: the CR held back from the previous item.
   hcbd_feed #(
      .SIZE_BITS     (SIZE_BITS),
      .LINE_LEN_BITS (LINE_LEN_BITS)
   ) u_feed_cr (
      .scan_en  (scan_en),
      .char_i   (CHAR_CR),
      .step_i   (step_ff),
      .len_i    (len_ff),
      .accum_i  (accum_ff),
      .max_line (max_line),
      .flags_o  (a_flags),
      .len_o    (a_len),
      .accum_o  (a_accum)
   );

   // Second feed: the current byte, after the held CR if there is one.
   assign b_step_i  = cr_ff ? a_flags.step : step_ff;
   assign b_len_i   = cr_ff ? a_len : len_ff;
   assign b_accum_i = cr_ff ? a_accum : accum_ff;

   hcbd_feed #(
      .SIZE_BITS     (SIZE_BITS),
      .LINE_LEN_BITS (LINE_LEN_BITS)
   ) u_feed_byte (
      .scan_en  (scan_en),
      .char_i   (in_byte),
      .step_i   (b_step_i),
      .len_i    (b_len_i),
      .accum_i  (b_accum_i),
      .max_line (max_line),
      .flags_o  (b_flags),
      .len_o    (b_len),
      .accum_o  (b_accum)
   );

   // Next state and result of one item.
   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      accum_in      = accum_ff;
      len_in        = len_ff;
      step_in       = step_ff;
      err_in        = err_ff;
      cr_in         = cr_ff;
      result        = '0;

      if (fire) begin
         case (phase_ff)
            PH_DATA: begin
               result.out_byte  = in_byte;
               result.out_valid = 1'b1;
               bytes_left_in    = bytes_dec;
               if (bytes_dec == '0) begin
                  phase_in = PH_SIZE;
                  len_in   = '0;
                  step_in  = SC_BLANKS;
                  accum_in = '0;
                  cr_in    = 1'b0;
               end
            end
            PH_SIZE, PH_TRAILER: begin
               if (in_byte == CHAR_LF) begin
                  // End of line.
                  cr_in    = 1'b0;
                  len_in   = '0;
                  step_in  = SC_BLANKS;
                  accum_in = '0;
                  if (phase_ff == PH_TRAILER) begin
                     if (len_ff == '0) begin
                        phase_in = PH_DONE;
                     end
                  end else if (len_ff != '0) begin
                     case (step_ff)
                        SC_ZERO, SC_DIGITS, SC_ACCEPT: begin
                           if (accum_ff == '0) begin
                              phase_in = PH_TRAILER;
                           end else begin
                              bytes_left_in = accum_ff;
                              phase_in      = PH_DATA;
                           end
                        end
                        SC_OVERFLOW: begin
                           err_in   = ERR_OVERFLOW;
                           phase_in = PH_ERROR;
                        end
                        default: begin
                           phase_in = phase_ff;
                        end
                     endcase
                  end
               end else if (in_byte == CHAR_CR) begin
                  // A CR is held back until it is known not to end the line.
                  cr_in = 1'b1;
                  if (cr_ff) begin
                     if (a_flags.too_long) begin
                        err_in   = ERR_LONG;
                        phase_in = PH_ERROR;
                        cr_in    = 1'b0;
                     end else begin
                        len_in   = a_len;
                        step_in  = a_flags.step;
                        accum_in = a_accum;
                     end
                  end
               end else begin
                  cr_in = 1'b0;
                  if (cr_ff && a_flags.too_long) begin
                     err_in   = ERR_LONG;
                     phase_in = PH_ERROR;
                  end else if (b_flags.too_long) begin
                     err_in   = ERR_LONG;
                     phase_in = PH_ERROR;
                  end else begin
                     len_in   = b_len;
                     step_in  = b_flags.step;
                     accum_in = b_accum;
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase

         // The stream must not end before the message is complete.
         if (in_ends && phase_in != PH_DONE && phase_in != PH_ERROR) begin
            err_in   = ERR_END;
            phase_in = PH_ERROR;
         end

         result.message_done = (phase_in == PH_DONE);
         result.error_code   = err_in;
      end
   end

   // Decoder state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE;
         bytes_left_ff <= '0;
         accum_ff      <= '0;
         len_ff        <= '0;
         step_ff       <= SC_BLANKS;
         err_ff        <= ERR_NONE;
         cr_ff         <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         accum_ff      <= accum_in;
         len_ff        <= len_in;
         step_ff       <= step_in;
         err_ff        <= err_in;
         cr_ff         <= cr_in;
      end
   end

endmodule

// File: tb/http_chunked_body_decoder_test.sv
module http_chunked_body_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hcbd_pkg::*;

   // One raw body byte as offered on the input side.
   typedef struct packed {
      logic [7:0] data;
      logic       ends;
   } body_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [11:0] csr_data = '0;

   http_chunked_body_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Body bytes waiting to be offered and decoded bytes waiting to come out.
   body_byte_type body_bytes_to_send[$];
   result_type expected_decoded[$];
   int         items_queued = 0;
   int         items_accepted = 0;
   int         results_seen = 0;
   int         mismatch_count = 0;

   // Line limit as last written, used to shape the generated lines.
   logic [11:0] gen_limit = MAX_LINE_RESET;

   // Decoder state as the checker sees it.
   phase_type     body_phase = PH_SIZE;
   scan_step_type scan_state = SC_BLANKS;
   logic [31:0]   payload_remaining = '0;
   logic [31:0]   size_value = '0;
   logic [11:0]   line_chars = '0;
   logic [1:0]    error_seen = ERR_NONE;
   logic          cr_held = 1'b0;
   logic [11:0]   line_limit = MAX_LINE_RESET;

   // Handshake pacing on both sides.
   int send_gap = 0;
   bit send_burst = 1'b0;
   int rsp_wait = 0;
   bit rsp_burst = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Decoder behavior.
   // ---------------------------------------------------------------------

   function automatic int hex_value_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) begin
         return int'(c) - 'h30;
      end
      if (c >= 8'h41 && c <= 8'h46) begin
         return int'(c) - 'h41 + 10;
      end
      if (c >= 8'h61 && c <= 8'h66) begin
         return int'(c) - 'h61 + 10;
      end
      return -1;
   endfunction

   function automatic bit is_line_blank(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == CHAR_CR;
   endfunction

   function automatic void enter_error(input logic [1:0] code);
      error_seen = code;
      body_phase = PH_ERROR;
   endfunction

   function automatic void restart_line();
      line_chars = '0;
      scan_state = SC_BLANKS;
      size_value = '0;
   endfunction

   // One more hex digit; a value that would not fit in 32 bits marks overflow.
   function automatic void take_digit(input int d);
      if (size_value > 32'h0FFF_FFFF) begin
         scan_state = SC_OVERFLOW;
      end else begin
         size_value = size_value * 32'd16 + 32'(d);
         scan_state = SC_DIGITS;
      end
   endfunction

   function automatic void scan_size_char(input logic [7:0] c);
      int d;
      d = hex_value_of(c);
      case (scan_state)
         SC_BLANKS: begin
            if (!is_line_blank(c)) begin
               if (c == CHAR_ZERO) begin
                  scan_state = SC_ZERO;
               end else if (d >= 0) begin
                  take_digit(d);
               end else if (c == CHAR_SEMI && line_chars == 0) begin
                  scan_state = SC_ACCEPT;
               end else begin
                  scan_state = SC_IGNORE;
               end
            end
         end
         SC_ZERO: begin
            if (c == CHAR_X_LO || c == CHAR_X_UP) begin
               scan_state = SC_ZERO_X;
            end else if (d >= 0) begin
               take_digit(d);
            end else begin
               scan_state = (c == CHAR_SEMI) ? SC_ACCEPT : SC_IGNORE;
            end
         end
         SC_ZERO_X: begin
            if (d >= 0) begin
               take_digit(d);
            end else begin
               scan_state = SC_IGNORE;
            end
         end
         SC_DIGITS: begin
            if (d >= 0) begin
               take_digit(d);
            end else begin
               scan_state = (c == CHAR_SEMI) ? SC_ACCEPT : SC_IGNORE;
            end
         end
         default: begin
         end
      endcase
   endfunction

   // A character that belongs to a size or trailer line.
   function automatic void line_char(input logic [7:0] c);
      if (line_chars >= line_limit) begin
         enter_error(ERR_LONG);
      end else begin
         if (body_phase == PH_SIZE) begin
            scan_size_char(c);
         end
         if (line_chars != 12'hFFF) begin
            line_chars++;
         end
      end
   endfunction

   function automatic void close_line();
      if (body_phase == PH_TRAILER) begin
         if (line_chars == 0) begin
            body_phase = PH_DONE;
         end
         restart_line();
      end else if (line_chars == 0) begin
         restart_line();
      end else begin
         case (scan_state)
            SC_ZERO, SC_DIGITS, SC_ACCEPT: begin
               if (size_value == 0) begin
                  body_phase = PH_TRAILER;
               end else begin
                  payload_remaining = size_value;
                  body_phase = PH_DATA;
               end
               restart_line();
            end
            SC_OVERFLOW: begin
               enter_error(ERR_OVERFLOW);
            end
            default: begin
               restart_line();
            end
         endcase
      end
   endfunction

   function automatic result_type decode_body_byte(input logic [7:0] b, input logic ends);
      result_type r;
      r = '0;
      if (body_phase == PH_DATA) begin
         r.out_byte = b;
         r.out_valid = 1'b1;
         payload_remaining = payload_remaining - 32'd1;
         if (payload_remaining == 0) begin
            body_phase = PH_SIZE;
            restart_line();
            cr_held = 1'b0;
         end
      end else if (body_phase == PH_SIZE || body_phase == PH_TRAILER) begin
         if (b == CHAR_LF) begin
            cr_held = 1'b0;
            close_line();
         end else if (b == CHAR_CR) begin
            // A CR only counts once it turns out not to precede the LF.
            if (cr_held) begin
               line_char(CHAR_CR);
            end
            cr_held = (body_phase != PH_ERROR);
         end else begin
            if (cr_held) begin
               cr_held = 1'b0;
               line_char(CHAR_CR);
            end
            if (body_phase != PH_ERROR) begin
               line_char(b);
            end
         end
      end
      if (ends && body_phase != PH_DONE && body_phase != PH_ERROR) begin
         enter_error(ERR_END);
      end
      r.message_done = (body_phase == PH_DONE);
      r.error_code = error_seen;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus building blocks.
   // ---------------------------------------------------------------------

   function automatic void queue_byte(input logic [7:0] value, input logic ends = 1'b0);
      body_bytes_to_send.push_back(body_byte_type'{data: value, ends: ends});
      items_queued++;
   endfunction

   function automatic void queue_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         queue_byte(s[i]);
      end
   endfunction

   function automatic void queue_line_end(input bit with_cr);
      if (with_cr) begin
         queue_byte(CHAR_CR);
      end
      queue_byte(CHAR_LF);
   endfunction

   function automatic void queue_line(input logic [7:0] chars[$], input bit with_cr);
      foreach (chars[i]) begin
         queue_byte(chars[i]);
      end
      queue_line_end(with_cr);
   endfunction

   function automatic int line_budget();
      return (gen_limit < 40) ? int'(gen_limit) : 40;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      if (nibble < 4'd10) begin
         return CHAR_ZERO + 8'(nibble);
      end
      return ($urandom_range(0, 1) ? "A" : "a") + 8'(nibble) - 8'd10;
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 4))
         0: return 8'h20;
         1: return 8'h09;
         2: return 8'h0B;
         3: return 8'h0C;
         default: return CHAR_CR;
      endcase
   endfunction

   function automatic logic [7:0] any_but_lf();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_LF);
      return c;
   endfunction

   // A character that makes a size line be ignored when it comes first.
   function automatic logic [7:0] junk_lead();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (hex_value_of(c) >= 0 || is_line_blank(c) || c == CHAR_SEMI || c == CHAR_LF);
      return c;
   endfunction

   // Size line with a nonzero size, then the payload and its line end.
   function automatic void queue_chunk();
      int unsigned size;
      int unsigned pick;
      int unsigned v;
      logic [7:0] line_q[$];
      logic [7:0] digits[$];
      pick = $urandom_range(0, 15);
      if (pick < 12) begin
         size = $urandom_range(1, 12);
      end else if (pick < 15) begin
         size = $urandom_range(13, 64);
      end else begin
         size = $urandom_range(65, 300);
      end
      v = size;
      while (v != 0) begin
         digits.push_front(hex_char(v[3:0]));
         v = v >> 4;
      end
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 8)) digits.push_front(CHAR_ZERO);
      end
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) line_q.push_back(blank_char());
      end
      if ($urandom_range(0, 3) == 0) begin
         line_q.push_back(CHAR_ZERO);
         line_q.push_back($urandom_range(0, 1) ? CHAR_X_LO : CHAR_X_UP);
      end
      foreach (digits[i]) begin
         line_q.push_back(digits[i]);
      end
      if ($urandom_range(0, 3) == 0) begin
         line_q.push_back(CHAR_SEMI);
         repeat ($urandom_range(0, 8)) line_q.push_back(any_but_lf());
      end
      // Short limits leave room for one digit only.
      if (line_q.size() > line_budget()) begin
         size = $urandom_range(1, 15);
         line_q.delete();
         line_q.push_back(hex_char(size[3:0]));
      end
      queue_line(line_q, 1'($urandom_range(0, 1)));
      repeat (size) queue_byte(8'($urandom_range(0, 255)));
      case ($urandom_range(0, 7))
         0: begin
         end
         1: queue_line_end(1'b0);
         default: queue_line_end(1'b1);
      endcase
   endfunction

   function automatic void queue_noise_line();
      int len;
      logic [7:0] line_q[$];
      len = $urandom_range(1, (line_budget() < 24) ? line_budget() : 24);
      line_q.push_back(junk_lead());
      repeat (len - 1) line_q.push_back(any_but_lf());
      queue_line(line_q, 1'($urandom_range(0, 1)));
   endfunction

   // Lines that look almost like a size line but must be skipped.
   function automatic void queue_malformed_line();
      logic [7:0] line_q[$];
      case ($urandom_range(0, 4))
         0: begin
            line_q.push_back($urandom_range(0, 1) ? "+" : "-");
            line_q.push_back(hex_char(4'($urandom_range(1, 15))));
         end
         1: begin
            line_q.push_back(CHAR_ZERO);
            line_q.push_back($urandom_range(0, 1) ? CHAR_X_LO : CHAR_X_UP);
            if ($urandom_range(0, 1)) begin
               line_q.push_back("g");
            end
         end
         2: begin
            repeat ($urandom_range(1, 3)) line_q.push_back(blank_char());
         end
         3: begin
            line_q.push_back(hex_char(4'($urandom_range(1, 15))));
            line_q.push_back(8'h20);
            line_q.push_back(hex_char(4'($urandom_range(1, 15))));
         end
         default: begin
            line_q.push_back(CHAR_ZERO);
            line_q.push_back("z");
         end
      endcase
      if (line_q.size() > line_budget()) begin
         line_q.delete();
         line_q.push_back("-");
      end
      queue_line(line_q, 1'($urandom_range(0, 1)));
   endfunction

   function automatic void queue_body_segments(input int target);
      int first_item;
      int unsigned pick;
      first_item = items_queued;
      while (items_queued - first_item < target) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            queue_chunk();
         end else if (pick == 6) begin
            queue_line_end(1'($urandom_range(0, 1)));
         end else if (pick <= 8) begin
            queue_noise_line();
         end else begin
            queue_malformed_line();
         end
      end
   endfunction

   // Closes the message in one of the ways it can end, then a few stray bytes.
   function automatic void queue_message_end();
      int first_item;
      int seg_len;
      int unsigned size;
      logic [7:0] line_q[$];
      logic [7:0] c;
      first_item = items_queued;
      case ($urandom_range(0, 3))
         0: begin
            // Zero chunk, trailer lines and the empty line that completes it.
            case ($urandom_range(0, 3))
               0: queue_text("0");
               1: queue_text("0x0;ext");
               2: queue_text(";ext");
               default: queue_text(" 000");
            endcase
            queue_line_end(1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 3)) begin
               line_q.delete();
               do c = any_but_lf(); while (c == CHAR_CR);
               line_q.push_back(c);
               repeat ($urandom_range(0, line_budget() - 1)) line_q.push_back(any_but_lf());
               queue_line(line_q, 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 1)) begin
               queue_byte(CHAR_CR);
            end
            queue_byte(CHAR_LF, 1'($urandom_range(0, 1)));
         end
         1: begin
            // Line one to three characters past the limit, size or trailer.
            if ($urandom_range(0, 1)) begin
               queue_text("0");
               queue_line_end(1'b1);
            end
            line_q.push_back(junk_lead());
            repeat (int'(gen_limit) + $urandom_range(0, 2)) line_q.push_back(any_but_lf());
            queue_line(line_q, 1'b1);
         end
         2: begin
            // More hex digits than 32 bits hold.
            line_q.push_back(hex_char(4'($urandom_range(1, 15))));
            repeat ($urandom_range(8, 11)) line_q.push_back(hex_char(4'($urandom_range(0, 15))));
            if ($urandom_range(0, 1)) begin
               line_q.push_back(CHAR_SEMI);
               line_q.push_back("x");
            end
            queue_line(line_q, 1'($urandom_range(0, 1)));
         end
         default: begin
            // Connection closes inside an unfinished chunk.
            size = $urandom_range(1, 12);
            queue_byte(hex_char(size[3:0]));
            queue_line_end(1'b1);
            repeat (size) queue_byte(8'($urandom_range(0, 255)));
            seg_len = items_queued - first_item;
            body_bytes_to_send[body_bytes_to_send.size() - 1 - $urandom_range(0, seg_len - 1)].ends
               = 1'b1;
         end
      endcase
      repeat (3) queue_byte(8'($urandom_range(0, 255)));
      queue_byte(8'($urandom_range(0, 255)), 1'b1);
   endfunction

   // ---------------------------------------------------------------------
   // Control helpers.
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 100) begin
         $display("%0t ns: %s", $time, what);
      end
   endtask

   task automatic wait_until_drained();
      while (items_accepted != items_queued || expected_decoded.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_line_limit(input logic [11:0] value);
      gen_limit = value;
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      line_limit = csr_data;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Input driver: offers queued body bytes and predicts each accepted item.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : byte_driver
      body_byte_type next_byte;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_decoded.push_back(decode_body_byte(req_tdata, req_tlast));
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (body_bytes_to_send.size() != 0) begin
               next_byte = body_bytes_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= next_byte.data;
               req_tlast <= next_byte.ends;
               if ($urandom_range(0, 63) == 0) begin
                  send_burst = !send_burst;
               end
               send_gap = send_burst ? 0 : $urandom_range(0, 3);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: checks every item and paces the ready line.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_decoded.size() == 0) begin
               report_mismatch($sformatf("result item %0d with none expected, data %h",
                                         results_seen, rsp_tdata));
            end else begin
               want = expected_decoded.pop_front();
               if (rsp_tdata[7:0] !== want.out_byte) begin
                  report_mismatch($sformatf("item %0d out_byte %h, expected %h",
                                            results_seen, rsp_tdata[7:0], want.out_byte));
               end
               if (rsp_tuser !== want.out_valid) begin
                  report_mismatch($sformatf("item %0d out_valid %b, expected %b",
                                            results_seen, rsp_tuser, want.out_valid));
               end
               if (rsp_tdata[8] !== want.message_done) begin
                  report_mismatch($sformatf("item %0d message_done %b, expected %b",
                                            results_seen, rsp_tdata[8], want.message_done));
               end
               if (rsp_tdata[10:9] !== want.error_code) begin
                  report_mismatch($sformatf("item %0d error_code %0d, expected %0d",
                                            results_seen, rsp_tdata[10:9], want.error_code));
               end
            end
            results_seen++;
            if ($urandom_range(0, 63) == 0) begin
               rsp_burst = !rsp_burst;
            end
            rsp_wait = rsp_burst ? 0 : $urandom_range(0, 3);
            // Now and then hold off long enough for the block to back up.
            if (results_seen % 700 == 250) begin
               rsp_wait = 80;
            end
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------
   initial begin : test_sequence
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: bare LF, blanks only, a sign, "0x" alone, upper case X with
      // payload 00, a VT blank with an extension and payload FF.
      queue_line_end(1'b0);
      queue_byte(CHAR_CR);
      queue_line_end(1'b1);
      queue_text("-1");
      queue_line_end(1'b0);
      queue_text("0x");
      queue_line_end(1'b1);
      queue_text("0X1");
      queue_line_end(1'b1);
      queue_byte(8'h00);
      queue_line_end(1'b1);
      queue_byte(8'h0B);
      queue_text("1;x");
      queue_line_end(1'b0);
      queue_byte(8'hFF);
      wait_until_drained();

      // Random body under several line limits, the extremes among them.
      queue_body_segments(370);
      wait_until_drained();
      write_line_limit(12'd4095);
      queue_body_segments(370);
      wait_until_drained();
      write_line_limit(12'd1);
      queue_body_segments(370);
      wait_until_drained();
      write_line_limit(12'($urandom_range(2, 24)));
      queue_body_segments(370);
      wait_until_drained();
      write_line_limit(12'($urandom_range(25, 4094)));
      queue_body_segments(370);
      wait_until_drained();

      // The message ends only once, so it closes the run.
      write_line_limit(12'($urandom_range(16, 40)));
      queue_message_end();
      wait_until_drained();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #4_800_000;
      $display("Verification failed");
      $finish;
   end

endmodule
